@@ rtl/crs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package crs_pkg;

  localparam int CoefWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int FieldWidth   = 32;
  localparam int NumTerms     = 6;

  // Flat matrix index (row * 3 + col) of factor k of determinant term t.
  // Terms 0..2 are added and terms 3..5 are subtracted.
  function automatic int term_idx(input int t, input int k);
    int idx;
    idx = 0;
    case (t)
      0: idx = (k == 0) ? 0 : (k == 1) ? 4 : 8;
      1: idx = (k == 0) ? 3 : (k == 1) ? 7 : 2;
      2: idx = (k == 0) ? 6 : (k == 1) ? 1 : 5;
      3: idx = (k == 0) ? 6 : (k == 1) ? 4 : 2;
      4: idx = (k == 0) ? 3 : (k == 1) ? 1 : 8;
      5: idx = (k == 0) ? 0 : (k == 1) ? 7 : 5;
      default: idx = 0;
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cramer_3x3_linear_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Pipelined 3x3 solver by Cramer's rule in signed fixed point. A new system is
// accepted every cycle while the output is not stalled. Seven stages form the
// determinant and the three numerators exactly, take magnitudes and check for
// overflow, COEF_WIDTH + 1 restoring-division stages produce one quotient bit
// each, and one stage saturates into the output register. When the output is
// stalled the whole pipeline holds. The low COEF_WIDTH bits of each input field
// are used; results are zero-extended.
module cramer_3x3_linear_solver #(
  parameter int COEF_WIDTH = crs_pkg::CoefWidthDef,
  parameter int FRAC_BITS  = crs_pkg::FracBitsDef
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  [crs_pkg::FieldWidth-1:0] row1_a_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row1_b_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row1_c_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row1_rhs_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row2_a_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row2_b_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row2_c_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row2_rhs_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row3_a_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row3_b_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row3_c_i,
  input  wire  [crs_pkg::FieldWidth-1:0] row3_rhs_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [crs_pkg::FieldWidth-1:0] solution_first_o,
  output logic [crs_pkg::FieldWidth-1:0] solution_second_o,
  output logic [crs_pkg::FieldWidth-1:0] solution_third_o,
  output logic                           singular_o,
  output logic                           saturated_o
);

  localparam int W   = COEF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int QW  = W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int SW  = DW + F + QW;
  localparam int NT  = crs_pkg::NumTerms;
  localparam int NST = 7 + QW + 1;

  logic [NST-1:0] vld_q;
  logic           adv;

  assign adv         = ~vld_q[NST-1] | out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Matrix 0 is the coefficient matrix; matrix k has column k-1 replaced.
  logic signed [W-1:0] a_in [9];
  logic signed [W-1:0] rhs  [3];
  logic signed [W-1:0] e    [4][9];

  assign a_in[0] = row1_a_i[W-1:0];
  assign a_in[1] = row1_b_i[W-1:0];
  assign a_in[2] = row1_c_i[W-1:0];
  assign a_in[3] = row2_a_i[W-1:0];
  assign a_in[4] = row2_b_i[W-1:0];
  assign a_in[5] = row2_c_i[W-1:0];
  assign a_in[6] = row3_a_i[W-1:0];
  assign a_in[7] = row3_b_i[W-1:0];
  assign a_in[8] = row3_c_i[W-1:0];
  assign rhs[0]  = row1_rhs_i[W-1:0];
  assign rhs[1]  = row2_rhs_i[W-1:0];
  assign rhs[2]  = row3_rhs_i[W-1:0];

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < 9; i++) begin
        e[m][i] = (m != 0 && (i % 3) == m - 1) ? rhs[i / 3] : a_in[i];
      end
    end
  end

  logic signed [2*W-1:0] p1_q  [4][NT];
  logic signed [W-1:0]   f3_q  [4][NT];
  logic signed [2*W:0]   pl_q  [4][NT];
  logic signed [2*W-1:0] ph_q  [4][NT];
  logic signed [DW-1:0]  tp_q  [4][NT];
  logic signed [DW-1:0]  sa_q  [4];
  logic signed [DW-1:0]  sb_q  [4];
  logic signed [DW-1:0]  det_q [4];

  for (genvar m = 0; m < 4; m++) begin : g_mat
    for (genvar t = 0; t < NT; t++) begin : g_term
      logic signed [2*W:0]   pl_d;
      logic signed [2*W-1:0] ph_d;
      logic signed [3*W-1:0] trip;

      assign pl_d = $signed({1'b0, p1_q[m][t][W-1:0]}) * f3_q[m][t];
      assign ph_d = $signed(p1_q[m][t][2*W-1:W]) * f3_q[m][t];
      assign trip = ((3*W)'(ph_q[m][t]) <<< W) + (3*W)'(pl_q[m][t]);

      always_ff @(posedge clk_i) begin
        if (adv) begin
          p1_q[m][t] <= e[m][crs_pkg::term_idx(t, 0)] * e[m][crs_pkg::term_idx(t, 1)];
          f3_q[m][t] <= e[m][crs_pkg::term_idx(t, 2)];
          pl_q[m][t] <= pl_d;
          ph_q[m][t] <= ph_d;
          tp_q[m][t] <= (t < 3) ? DW'(trip) : -DW'(trip);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sa_q[m]  <= tp_q[m][0] + tp_q[m][1] + tp_q[m][2];
        sb_q[m]  <= tp_q[m][3] + tp_q[m][4] + tp_q[m][5];
        det_q[m] <= sa_q[m] + sb_q[m];
      end
    end
  end

  // Magnitudes and signs.
  logic [DW-1:0] nmag_q [3];
  logic [DW-1:0] dmag_q;
  logic [2:0]    neg6_q;
  logic          sing6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmag_q  <= det_q[0][DW-1] ? DW'(-det_q[0]) : DW'(det_q[0]);
      sing6_q <= (det_q[0] == '0);
      for (int k = 0; k < 3; k++) begin
        nmag_q[k] <= det_q[k+1][DW-1] ? DW'(-det_q[k+1]) : DW'(det_q[k+1]);
        neg6_q[k] <= det_q[k+1][DW-1] ^ det_q[0][DW-1];
      end
    end
  end

  // Division pipeline. Index 0 is loaded from the overflow check stage.
  logic [DW-1:0] rem_q  [QW+1][3];
  logic [QW-1:0] nlo_q  [QW+1][3];
  logic [QW-1:0] quo_q  [QW+1][3];
  logic [DW-1:0] dv_q   [QW+1];
  logic [2:0]    neg_q  [QW+1];
  logic [2:0]    ovf_q  [QW+1];
  logic          sing_q [QW+1];

  always_ff @(posedge clk_i) begin
    logic [SW-1:0] nsh;
    logic [SW-1:0] dsh;
    if (adv) begin
      dv_q[0]   <= dmag_q;
      neg_q[0]  <= neg6_q;
      sing_q[0] <= sing6_q;
      dsh = SW'(dmag_q) << QW;
      for (int k = 0; k < 3; k++) begin
        nsh = SW'(nmag_q[k]) << F;
        // A quotient of QW bits or more saturates in any case.
        ovf_q[0][k]  <= (nsh >= dsh);
        rem_q[0][k]  <= DW'(nsh >> QW);
        nlo_q[0][k]  <= nsh[QW-1:0];
        quo_q[0][k]  <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    for (genvar k = 0; k < 3; k++) begin : g_unit
      logic [DW:0] trial;
      logic        ge;

      assign trial = {rem_q[j][k], nlo_q[j][k][QW-1-j]};
      assign ge    = (trial >= {1'b0, dv_q[j]});

      always_ff @(posedge clk_i) begin
        if (adv) begin
          rem_q[j+1][k] <= ge ? DW'(trial - {1'b0, dv_q[j]}) : DW'(trial);
          nlo_q[j+1][k] <= nlo_q[j][k];
          quo_q[j+1][k] <= {quo_q[j][k][QW-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[j+1]   <= dv_q[j];
        neg_q[j+1]  <= neg_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        sing_q[j+1] <= sing_q[j];
      end
    end
  end

  // Saturation and sign into the output register.
  logic [W-1:0] sol_d [3];
  logic [2:0]   sat_d;

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    for (int k = 0; k < 3; k++) begin
      lim = neg_q[QW][k] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
      sat_d[k] = ovf_q[QW][k] | (quo_q[QW][k] > lim);
      mag = sat_d[k] ? lim : quo_q[QW][k];
      sol_d[k] = neg_q[QW][k] ? W'(-mag) : W'(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      singular_o        <= sing_q[QW];
      saturated_o       <= ~sing_q[QW] & (|sat_d);
      solution_first_o  <= sing_q[QW] ? '0 : crs_pkg::FieldWidth'(sol_d[0]);
      solution_second_o <= sing_q[QW] ? '0 : crs_pkg::FieldWidth'(sol_d[1]);
      solution_third_o  <= sing_q[QW] ? '0 : crs_pkg::FieldWidth'(sol_d[2]);
    end
  end

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;

  typedef logic [31:0] coef_set_t [12];
  typedef logic signed [127:0] wide_mat_t [9];

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        singular;
    logic        saturated;
  } solution_t;

  localparam int unsigned FracBits = crs_pkg::FracBitsDef;
  localparam logic signed [127:0] QMax = 128'sd2147483647;
  localparam logic signed [127:0] QMin = -128'sd2147483648;
  localparam int unsigned MaxShown = 10;
  localparam int unsigned DrainCycles = 60;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic out_valid;
  logic out_ready;
  logic [31:0] coef [12];
  logic [31:0] sol_x, sol_y, sol_z;
  logic sol_singular, sol_saturated;

  logic idle_en;
  int unsigned stall_left;
  int unsigned mismatches;
  solution_t expected_q[$];

  cramer_3x3_linear_solver u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .row1_a_i         (coef[0]),
    .row1_b_i         (coef[1]),
    .row1_c_i         (coef[2]),
    .row1_rhs_i       (coef[3]),
    .row2_a_i         (coef[4]),
    .row2_b_i         (coef[5]),
    .row2_c_i         (coef[6]),
    .row2_rhs_i       (coef[7]),
    .row3_a_i         (coef[8]),
    .row3_b_i         (coef[9]),
    .row3_c_i         (coef[10]),
    .row3_rhs_i       (coef[11]),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .solution_first_o (sol_x),
    .solution_second_o(sol_y),
    .solution_third_o (sol_z),
    .singular_o       (sol_singular),
    .saturated_o      (sol_saturated)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic signed [127:0] det3(wide_mat_t a);
    return a[0] * a[4] * a[8] + a[3] * a[7] * a[2] + a[6] * a[1] * a[5]
         - a[6] * a[4] * a[2] - a[3] * a[1] * a[8] - a[0] * a[7] * a[5];
  endfunction

  function automatic logic [31:0] scaled_quotient(logic signed [127:0] num,
                                                  logic signed [127:0] det,
                                                  ref logic clipped);
    logic signed [127:0] q;
    q = (num <<< FracBits) / det;
    if (q > QMax) begin
      clipped = 1'b1;
      return 32'h7fff_ffff;
    end else if (q < QMin) begin
      clipped = 1'b1;
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  function automatic solution_t solve_system(coef_set_t c);
    wide_mat_t m, t;
    logic signed [127:0] rhs [3];
    logic signed [127:0] det;
    logic [31:0] sol [3];
    logic clipped;
    solution_t r;
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        m[row*3+col] = {{96{c[row*4+col][31]}}, c[row*4+col]};
      end
      rhs[row] = {{96{c[row*4+3][31]}}, c[row*4+3]};
    end
    det = det3(m);
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    clipped = 1'b0;
    for (int k = 0; k < 3; k++) begin
      t = m;
      for (int row = 0; row < 3; row++) t[row*3+k] = rhs[row];
      sol[k] = scaled_quotient(det3(t), det, clipped);
    end
    r.x = sol[0];
    r.y = sol[1];
    r.z = sol[2];
    r.saturated = clipped;
    return r;
  endfunction

  // Drives one system and holds it until the solver accepts it.
  task automatic send_system(coef_set_t c);
    in_valid <= 1'b1;
    for (int i = 0; i < 12; i++) coef[i] <= c[i];
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(solve_system(c));
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    solution_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {sol_x, sol_y, sol_z, sol_singular, sol_saturated};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("Unexpected transaction: %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxShown) begin
            $display("Mismatch: expected x=%h y=%h z=%h sing=%b sat=%b",
                     want.x, want.y, want.z, want.singular, want.saturated);
            $display("          actual   x=%h y=%h z=%h sing=%b sat=%b",
                     got.x, got.y, got.z, got.singular, got.saturated);
          end
        end
      end
    end
  end

  function automatic coef_set_t identity_system(logic [31:0] diag, logic [31:0] r1,
                                                logic [31:0] r2, logic [31:0] r3);
    coef_set_t c;
    foreach (c[i]) c[i] = '0;
    c[0] = diag;
    c[5] = diag;
    c[10] = diag;
    c[3] = r1;
    c[7] = r2;
    c[11] = r3;
    return c;
  endfunction

  task automatic test_directed();
    coef_set_t c;
    foreach (c[i]) c[i] = '0;
    send_system(c);                                 // all zero: singular
    send_system(identity_system(32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
    send_system(identity_system(32'h0001_0000, 32'hffff_ffff, 32'h1, 32'h1234_5678));
    // Tiny determinant with large right-hand sides forces clipping both ways.
    send_system(identity_system(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h1));
    send_system(identity_system(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0));
    send_system(identity_system(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
    // Division by three with a negative result checks truncation toward zero.
    send_system(identity_system(32'h0003_0000, 32'hffff_fffe, 32'h0000_0002, 32'hffff_ffff));
    foreach (c[i]) c[i] = 32'h7fff_ffff;
    send_system(c);                                 // equal rows: singular
    foreach (c[i]) c[i] = 32'h8000_0000;
    send_system(c);
    foreach (c[i]) c[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
    c[5] = 32'h0;
    send_system(c);
    foreach (c[i]) c[i] = 32'hffff_ffff;
    c[0] = 32'h0;
    c[9] = 32'h1;
    send_system(c);
  endtask

  function automatic coef_set_t random_system();
    coef_set_t c;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    foreach (c[i]) c[i] = $urandom();
    if (kind < 6) begin
      // Moderate coefficients with a strong diagonal give in-range answers.
      for (int row = 0; row < 3; row++) begin
        for (int col = 0; col < 3; col++) begin
          c[row*4+col] = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        end
        c[row*5] = c[row*5] + ($urandom_range(0, 1) ? 32'h0004_0000 : 32'hfffc_0000);
        if (kind < 3) c[row*4+3] = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      end
    end else if (kind == 6) begin
      for (int col = 0; col < 4; col++) c[8+col] = c[col];   // repeated row
    end else if (kind == 7) begin
      for (int i = 0; i < 12; i++) c[i] = {{24{c[i][7]}}, c[i][7:0]};
    end
    return c;
  endfunction

  task automatic test_random(int unsigned count);
    repeat (count) send_system(random_system());
  endtask

  task automatic test_back_to_back(int unsigned count);
    idle_en = 1'b0;
    repeat (count) send_system(random_system());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    idle_en = 1'b1;
    mismatches = 0;
    foreach (coef[i]) coef[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(850);
    test_back_to_back(150);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
